// ===== sv/asp_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the A* search core.
`timescale 1ns / 1ps
`default_nettype none
package asp_pkg;

	localparam int MAX_VERTICES_DEF  = 32;
	localparam int WEIGHT_BITS_DEF   = 16;
	localparam int VERTEX_FIELD_BITS = 5;
	localparam int VALUE_BITS        = 16;
	localparam int ACTIVE_BITS       = 6;
	localparam int LIMIT_BITS        = 6;

	localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 6'd32;
	localparam logic [LIMIT_BITS-1:0]  RESULT_LIMIT = 6'd32;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] VS_UNVISITED = 2'd0;
	localparam logic [1:0] VS_OPEN      = 2'd1;
	localparam logic [1:0] VS_CLOSED    = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MIN,
		S_PICK,
		S_RD,
		S_REL,
		S_TRACE,
		S_EMIT,
		S_NOTFOUND
	} state_t;

	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic load_edge;
		logic search_start;
		logic min_step;
		logic pick;
		logic rd;
		logic rel;
		logic tr_step;
		logic emit_path;
		logic emit_nf;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic search_bad;
		logic scan_end;
		logic best_valid;
		logic best_is_goal;
		logic nbr_end;
		logic trace_done;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/asp_ctrl.sv =====
// Controller state machine sequencing load, clear, search, trace and result output.
`timescale 1ns / 1ps
`default_nettype none
module asp_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic [1:0]  action,
	output logic             s_tready,
	input  asp_pkg::sts_t    sts,
	output asp_pkg::cmd_t    cmd
);
	import asp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (action)
						ACT_LOAD: begin
							cmd.load_edge = 1'b1;
						end
						ACT_SEARCH: begin
							cmd.search_start = 1'b1;
							state_d = sts.search_bad ? S_NOTFOUND : S_MIN;
						end
						ACT_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d = S_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			S_MIN: begin
				cmd.min_step = 1'b1;
				if (sts.scan_end) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				if (!sts.best_valid) begin
					state_d = S_NOTFOUND;
				end else if (sts.best_is_goal) begin
					state_d = S_TRACE;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = sts.nbr_end ? S_MIN : S_REL;
			end
			S_REL: begin
				cmd.rel = 1'b1;
				state_d = S_RD;
			end
			S_TRACE: begin
				cmd.tr_step = 1'b1;
				if (sts.trace_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_path = 1'b1;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_NOTFOUND: begin
				if (sts.out_free) begin
					cmd.emit_nf = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/asp_dp.sv =====
// Datapath: weight memory, vertex tables, open-set scan, relaxation, trail and output register.
`timescale 1ns / 1ps
`default_nettype none
module asp_dp #(
	parameter int MAX_VERTICES = asp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = asp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  asp_pkg::cmd_t                              cmd,
	output asp_pkg::sts_t                              sts,
	input  wire logic [asp_pkg::VERTEX_FIELD_BITS-1:0] from_vertex,
	input  wire logic [asp_pkg::VERTEX_FIELD_BITS-1:0] to_vertex,
	input  wire logic [asp_pkg::VALUE_BITS-1:0]        edge_weight,
	input  wire logic [asp_pkg::VALUE_BITS-1:0]        heuristic_value,
	input  wire logic                                  cfg_valid,
	input  wire logic [asp_pkg::ACTIVE_BITS-1:0]       cfg_data,
	input  wire logic                                  m_tready,
	output logic                                       out_valid,
	output logic [asp_pkg::VERTEX_FIELD_BITS-1:0]      out_vertex,
	output logic                                       out_found,
	output logic                                       out_last
);
	import asp_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CNTW  = VW + 1;
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = WEIGHT_BITS + VW;
	localparam int FW    = ((CW > VALUE_BITS) ? CW : VALUE_BITS) + 1;
	localparam int SW    = VW + 1;
	localparam logic [8:0] MAX9 = 9'(MAX_VERTICES);
	localparam logic [CNTW-1:0] LAST_IDX = CNTW'(MAX_VERTICES - 1);

	logic [WEIGHT_BITS-1:0] wmem [DEPTH];
	logic [WEIGHT_BITS-1:0] rdata_q;
	logic [AW-1:0]          clr_addr_q;

	logic [VALUE_BITS-1:0] heur_q   [MAX_VERTICES];
	logic [1:0]            status_q [MAX_VERTICES];
	logic [CW-1:0]         cost_q   [MAX_VERTICES];
	logic [VW-1:0]         parent_q [MAX_VERTICES];
	logic [SW-1:0]         stamp_q  [MAX_VERTICES];
	logic [VW-1:0]         trail_q  [MAX_VERTICES];

	logic [ACTIVE_BITS-1:0] active_q;
	logic [VW-1:0]   start_q, goal_q, best_q, cur_q, tv_q, e_q;
	logic [CNTW-1:0] n_q, v_q, i_q, len_q;
	logic [FW-1:0]   best_f_q;
	logic [SW-1:0]   best_stamp_q, next_stamp_q;
	logic            best_valid_q;
	logic [CW-1:0]   cur_cost_q;
	logic [LIMIT_BITS-1:0] cnt_q, k_q;

	logic [8:0]      a9, b9, act9, lp1, trail9;
	logic            a_ok, b_ok;
	logic [VW-1:0]   av, bv, vi, ii;
	logic [FW-1:0]   f;
	logic            better;
	logic [CW-1:0]   t;
	logic            rel_ok, rel_new, rel_upd;
	logic [31:0]     w32;

	assign a9   = 9'(from_vertex);
	assign b9   = 9'(to_vertex);
	assign a_ok = a9 < MAX9;
	assign b_ok = b9 < MAX9;
	assign av   = a9[VW-1:0];
	assign bv   = b9[VW-1:0];
	assign act9 = 9'(active_q);
	assign w32  = 32'(edge_weight);

	assign vi = v_q[VW-1:0];
	assign f  = FW'(cost_q[vi]) + FW'(heur_q[vi]);
	assign better = (status_q[vi] == VS_OPEN) && (!best_valid_q || (f < best_f_q) ||
		((f == best_f_q) && (stamp_q[vi] > best_stamp_q)));

	assign ii      = i_q[VW-1:0];
	assign t       = cur_cost_q + CW'(rdata_q);
	assign rel_ok  = (rdata_q != '0) && (status_q[ii] != VS_CLOSED);
	assign rel_new = rel_ok && (status_q[ii] == VS_UNVISITED);
	assign rel_upd = rel_ok && (status_q[ii] == VS_OPEN) && (t < cost_q[ii]);

	assign lp1    = 9'(len_q) + 9'd1;
	assign trail9 = 9'(trail_q[e_q]);

	assign sts.clear_done   = clr_addr_q == {AW{1'b1}};
	assign sts.search_bad   = !a_ok || !b_ok;
	assign sts.scan_end     = v_q == LAST_IDX;
	assign sts.best_valid   = best_valid_q;
	assign sts.best_is_goal = best_q == goal_q;
	assign sts.nbr_end      = i_q == n_q;
	assign sts.trace_done   = (tv_q == start_q) || (len_q == LAST_IDX);
	assign sts.emit_last    = (k_q + 1'b1) == cnt_q;
	assign sts.out_free     = !out_valid || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			wmem[clr_addr_q] <= '0;
		end else if (cmd.load_edge && a_ok && b_ok) begin
			wmem[{av, bv}] <= w32[WEIGHT_BITS-1:0];
		end
		if (cmd.rd) begin
			rdata_q <= wmem[{cur_q, ii}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			active_q   <= ACTIVE_RESET;
		end else begin
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg_valid) begin
				active_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				heur_q[k] <= '0;
			end
		end else if (cmd.clr_start) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				heur_q[k] <= '0;
			end
		end else if (cmd.load_edge && a_ok && b_ok) begin
			heur_q[av] <= heuristic_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				status_q[k] <= VS_UNVISITED;
			end
		end else if (cmd.search_start && a_ok && b_ok) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				status_q[k] <= (k == int'(av)) ? VS_OPEN : VS_UNVISITED;
			end
		end else if (cmd.pick && best_valid_q && (best_q != goal_q)) begin
			status_q[best_q] <= VS_CLOSED;
		end else if (cmd.rel && rel_new) begin
			status_q[ii] <= VS_OPEN;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_start && a_ok && b_ok) begin
			cost_q[av]   <= '0;
			parent_q[av] <= av;
			stamp_q[av]  <= '0;
			next_stamp_q <= SW'(1);
			start_q      <= av;
			goal_q       <= bv;
			n_q          <= (act9 > MAX9) ? CNTW'(MAX_VERTICES) : CNTW'(active_q);
		end else if (cmd.rel && (rel_new || rel_upd)) begin
			cost_q[ii]   <= t;
			parent_q[ii] <= cur_q;
			if (rel_new) begin
				stamp_q[ii]  <= next_stamp_q;
				next_stamp_q <= next_stamp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_start || (cmd.rd && sts.nbr_end)) begin
			v_q <= '0;
			best_valid_q <= 1'b0;
		end else if (cmd.min_step) begin
			v_q <= v_q + 1'b1;
			if (better) begin
				best_valid_q <= 1'b1;
				best_q       <= vi;
				best_f_q     <= f;
				best_stamp_q <= stamp_q[vi];
			end
		end
		if (cmd.pick) begin
			cur_q      <= best_q;
			cur_cost_q <= cost_q[best_q];
			i_q        <= '0;
			tv_q       <= goal_q;
			len_q      <= '0;
		end else if (cmd.rel) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.tr_step) begin
			trail_q[len_q[VW-1:0]] <= tv_q;
			if (sts.trace_done) begin
				e_q   <= len_q[VW-1:0];
				cnt_q <= (lp1 > 9'(RESULT_LIMIT)) ? RESULT_LIMIT : lp1[LIMIT_BITS-1:0];
				k_q   <= '0;
			end else begin
				len_q <= len_q + 1'b1;
				tv_q  <= parent_q[tv_q];
			end
		end else if (cmd.emit_path) begin
			e_q <= e_q - 1'b1;
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_path || cmd.emit_nf) begin
			out_valid <= 1'b1;
		end else if (m_tready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_path) begin
			out_vertex <= trail9[VERTEX_FIELD_BITS-1:0];
			out_found  <= 1'b1;
			out_last   <= sts.emit_last;
		end else if (cmd.emit_nf) begin
			out_vertex <= '0;
			out_found  <= 1'b0;
			out_last   <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/astar_shortest_path_core.sv =====
// Top level of the A* shortest-path core over an adjacency-matrix graph.
// Load item: taken in the idle state, which it does not leave. Clear item: zeroes
// all 2^(2*clog2(MAX_VERTICES)) (1024) weight-memory words. Search item: per expansion
// an open-set scan of all MAX_VERTICES vertices, a pick step and a read and relax step
// per neighbour through the single-port weight memory, then the path trace. The path
// streams out one item per cycle while m_tready is high, start vertex first, tlast on
// the goal. After reset a clearing pass zeroes the weight memory; no item is taken.
`timescale 1ns / 1ps
`default_nettype none
module astar_shortest_path_core #(
	parameter int MAX_VERTICES = asp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = asp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // from_vertex, to_vertex, edge_weight, heuristic_value
	input  wire logic [1:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // path_vertex
	output logic [0:0]       m_tuser,  // found
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data
);
	import asp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [VERTEX_FIELD_BITS-1:0] out_vertex;

	assign cfg_ready = 1'b1;
	assign m_tdata   = 8'(out_vertex);

	asp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	asp_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.from_vertex     (s_tdata[4:0]),
		.to_vertex       (s_tdata[9:5]),
		.edge_weight     (s_tdata[25:10]),
		.heuristic_value (s_tdata[41:26]),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.m_tready        (m_tready),
		.out_valid       (m_tvalid),
		.out_vertex      (out_vertex),
		.out_found       (m_tuser[0]),
		.out_last        (m_tlast)
	);

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_SEARCH) |=> !s_tready)
		else $error("search item did not hold off the input");

	a_nf_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("not-found result without tlast");

	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == 8'd0))
		else $error("not-found result with nonzero vertex");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the A* shortest-path core, with a built-in path predictor.
`timescale 1ns / 1ps
module tb;
	import asp_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int NV = 32;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 1200;

	typedef struct packed {
		logic [4:0] vertex;
		logic       found;
		logic       last;
	} path_item_t;

	typedef struct packed {
		logic [1:0]  act;
		logic [4:0]  src;
		logic [4:0]  dst;
		logic [15:0] weight;
		logic [15:0] heur;
		logic        typed;
		logic [4:0]  exp_vertex;
		logic        exp_found;
	} drow_t;

	localparam drow_t DIRECTED [20] = '{
		'{ACT_SEARCH, 5'd0, 5'd0, 16'd0, 16'd0, 1'b1, 5'd0, 1'b1},
		'{ACT_SEARCH, 5'd0, 5'd5, 16'd0, 16'd0, 1'b1, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd31, 5'd31, 16'd0, 16'd0, 1'b1, 5'd31, 1'b1},
		'{ACT_LOAD, 5'd0, 5'd1, 16'hFFFF, 16'hFFFF, 1'b0, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd1, 5'd2, 16'd1, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd0, 5'd31, 16'd1, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd31, 5'd2, 16'd1, 16'hFFFF, 1'b0, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd0, 5'd2, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd2, 5'd0, 16'd0, 16'd0, 1'b1, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd5, 5'd6, 16'd0, 16'd7, 1'b0, 5'd0, 1'b0},
		'{ACT_UNUSED, 5'd0, 5'd2, 16'hFFFF, 16'hFFFF, 1'b0, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd0, 5'd31, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd1, 5'd2, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_CLEAR, 5'd0, 5'd0, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd0, 5'd2, 16'd0, 16'd0, 1'b1, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd4, 5'd5, 16'd2, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd4, 5'd6, 16'd1, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd6, 5'd5, 16'd1, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_LOAD, 5'd5, 5'd7, 16'd1, 16'd0, 1'b0, 5'd0, 1'b0},
		'{ACT_SEARCH, 5'd4, 5'd7, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	logic [15:0] edge_cost [NV][NV];
	logic [15:0] vertex_heur [NV];
	logic [5:0]  scan_count;
	path_item_t  pending_paths [$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	int          quiet_cycles;

	astar_shortest_path_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void predict_search(input logic [4:0] s, input logic [4:0] g);
		logic [1:0] status [NV];
		longint     cost [NV];
		int         parent [NV];
		int         stamp [NV];
		int         trail [$];
		int         n;
		int         next_stamp;
		int         best;
		int         v;
		longint     best_f;
		longint     f;
		longint     t;
		bit         done;
		path_item_t r;
		n = (scan_count > NV) ? NV : scan_count;
		for (int i = 0; i < NV; i++) begin
			status[i] = VS_UNVISITED;
			cost[i] = 0;
			parent[i] = 0;
			stamp[i] = 0;
		end
		status[s] = VS_OPEN;
		parent[s] = s;
		next_stamp = 1;
		done = 0;
		while (!done) begin
			best = -1;
			best_f = 0;
			for (int i = 0; i < NV; i++) begin
				if (status[i] == VS_OPEN) begin
					f = cost[i] + vertex_heur[i];
					if (best < 0 || f < best_f || (f == best_f && stamp[i] > stamp[best])) begin
						best = i;
						best_f = f;
					end
				end
			end
			if (best < 0) begin
				r = '{vertex: 5'd0, found: 1'b0, last: 1'b1};
				pending_paths = {pending_paths, r};
				done = 1;
			end else if (best == g) begin
				v = g;
				while (trail.size() < NV) begin
					trail.push_front(v);
					if (v == s)
						break;
					v = parent[v];
				end
				foreach (trail[k]) begin
					r = '{vertex: trail[k][4:0], found: 1'b1, last: k == trail.size() - 1};
					pending_paths = {pending_paths, r};
				end
				done = 1;
			end else begin
				status[best] = VS_CLOSED;
				for (int i = 0; i < n; i++) begin
					if (edge_cost[best][i] != 0 && status[i] != VS_CLOSED) begin
						t = cost[best] + edge_cost[best][i];
						if (status[i] == VS_UNVISITED) begin
							status[i] = VS_OPEN;
							cost[i] = t;
							parent[i] = best;
							stamp[i] = next_stamp++;
						end else if (t < cost[i]) begin
							cost[i] = t;
							parent[i] = best;
						end
					end
				end
			end
		end
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [4:0] a, input logic [4:0] b,
			input logic [15:0] w, input logic [15:0] h, input bit typed = 0,
			input logic [4:0] exp_vertex = 0, input bit exp_found = 0);
		path_item_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tuser = act;
		s_tdata = {6'd0, h, w, b, a};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		case (act)
			ACT_LOAD: begin
				edge_cost[a][b] = w;
				vertex_heur[a] = h;
			end
			ACT_SEARCH: begin
				if (typed) begin
					r = '{vertex: exp_vertex, found: exp_found, last: 1'b1};
					pending_paths = {pending_paths, r};
				end else begin
					predict_search(a, b);
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < NV; i++) begin
					vertex_heur[i] = '0;
					for (int j = 0; j < NV; j++)
						edge_cost[i][j] = '0;
				end
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_scan_count(input logic [5:0] value);
		s_tvalid = 1'b0;
		while (pending_paths.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		scan_count = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [15:0] pick_weight();
		return ($urandom_range(9) < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_heur();
		return ($urandom_range(9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
	endfunction

	task automatic random_items(input int target);
		int sent;
		int len;
		int base;
		int span;
		sent = 0;
		while (sent < target) begin
			case ($urandom_range(9))
				0: begin
					len = $urandom_range(2, 32);
					send_item(ACT_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom));
					for (int i = 0; i + 1 < len; i++)
						send_item(ACT_LOAD, 5'(i), 5'(i + 1), pick_weight(), pick_heur());
					send_item(ACT_SEARCH, 5'd0, 5'(len - 1), 0, 0);
					send_item(ACT_SEARCH, 5'(len - 1), 5'd0, 0, 0);
					sent += len + 2;
				end
				1, 2, 3, 4, 5, 6: begin
					if ($urandom_range(2) == 0) begin
						send_item(ACT_CLEAR, 0, 0, 0, 0);
						sent++;
					end
					base = $urandom_range(31);
					span = $urandom_range(3, 8);
					repeat ($urandom_range(4, 12)) begin
						send_item(ACT_LOAD, 5'(base + $urandom_range(span - 1)),
							5'(base + $urandom_range(span - 1)), pick_weight(), pick_heur());
						sent++;
					end
					repeat (3) begin
						send_item(ACT_SEARCH, 5'(base + $urandom_range(span - 1)),
							5'(base + $urandom_range(span - 1)), 16'($urandom), 16'($urandom));
						sent++;
					end
					if ($urandom_range(4) == 0) begin
						s_tvalid = 1'b0;
						while (pending_paths.size() != 0)
							@(negedge clk);
						@(negedge clk);
					end
				end
				default: begin
					len = $urandom_range(3);
					send_item(2'(len), 5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom));
					if (len != ACT_UNUSED)
						sent++;
				end
			endcase
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready = 1'b0;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		path_item_t want;
		if (m_tvalid && m_tready) begin
			if (pending_paths.size() == 0) begin
				report_mismatch("unexpected result, vertex", m_tdata[4:0], -1);
			end else begin
				want = pending_paths.pop_front();
				if (m_tdata != {3'd0, want.vertex})
					report_mismatch("path_vertex", m_tdata, want.vertex);
				if (m_tuser[0] != want.found)
					report_mismatch("found", m_tuser[0], want.found);
				if (m_tlast != want.last)
					report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [5:0] settings [6];
		errors = 0;
		quiet_cycles = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_LOAD;
		cfg_valid = 1'b0;
		cfg_data = '0;
		scan_count = ACTIVE_RESET;
		for (int i = 0; i < NV; i++) begin
			vertex_heur[i] = '0;
			for (int j = 0; j < NV; j++)
				edge_cost[i][j] = '0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_item(DIRECTED[i].act, DIRECTED[i].src, DIRECTED[i].dst, DIRECTED[i].weight,
				DIRECTED[i].heur, DIRECTED[i].typed, DIRECTED[i].exp_vertex,
				DIRECTED[i].exp_found);

		settings = '{6'd32, 6'd1, 6'd63, 6'd0, 6'($urandom_range(2, 31)), 6'd32};
		foreach (settings[p]) begin
			write_scan_count(settings[p]);
			send_idle_pct = (p % 4 == 1) ? 67 : (p % 4 == 3) ? 34 : 0;
			recv_stall_pct = (p % 4 == 2) ? 67 : (p % 4 == 3) ? 34 : 0;
			if (p == 2)
				hold_cycles = 4000;
			random_items(25);
		end

		s_tvalid = 1'b0;
		while (pending_paths.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== astar_shortest_path_core.f =====
sv/asp_pkg.sv
sv/asp_ctrl.sv
sv/asp_dp.sv
sv/astar_shortest_path_core.sv
verif/tb.sv
